FILE: hdl/fmr_pkg.sv
`default_nettype none
package fmr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FRAME_LEN = 6;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned SCALE_SH  = 4;
  localparam int unsigned OUT_W     = 22;
  // three 8-bit values times 16, summed
  localparam int unsigned MIX_W     = BYTE_W + SCALE_SH + 2;
  localparam int unsigned WIDE_W    = OUT_W + FRAC_BITS;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER  = 1'b0,
    REG_TRAILER = 1'b1
  } cfg_reg_e;

  localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hA5;
  localparam logic [BYTE_W-1:0] TRAILER_RST = 8'h5A;

  typedef struct packed {
    logic signed [BYTE_W-1:0] x;
    logic signed [BYTE_W-1:0] y;
    logic signed [BYTE_W-1:0] r;
  } frame_t;

  localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

  // scale a mixed speed into fixed point, clamped to the output range
  function automatic logic signed [OUT_W-1:0] to_ref(logic signed [MIX_W-1:0] mix);
    logic signed [WIDE_W-1:0] w;
    logic signed [OUT_W-1:0]  res;
    w = WIDE_W'(mix) <<< FRAC_BITS;
    if (w > SAT_HI) begin
      res = SAT_HI[OUT_W-1:0];
    end else if (w < SAT_LO) begin
      res = SAT_LO[OUT_W-1:0];
    end else begin
      res = w[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/fmr_parse.sv
`default_nettype none
module fmr_parse (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic [fmr_pkg::BYTE_W-1:0]            rx_byte_i,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [fmr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [fmr_pkg::BYTE_W-1:0]            cfg_data_i,
  input  wire logic                                  q_full_i,
  output logic                                       q_push_o,
  output fmr_pkg::frame_t                            q_data_o
);

  typedef enum logic {
    ST_IDLE,
    ST_FRAME
  } state_e;

  localparam logic [fmr_pkg::IDX_W-1:0] IDX_FIRST = fmr_pkg::IDX_W'(1);
  localparam logic [fmr_pkg::IDX_W-1:0] IDX_X     = fmr_pkg::IDX_W'(1);
  localparam logic [fmr_pkg::IDX_W-1:0] IDX_Y     = fmr_pkg::IDX_W'(2);
  localparam logic [fmr_pkg::IDX_W-1:0] IDX_R     = fmr_pkg::IDX_W'(3);
  localparam logic [fmr_pkg::IDX_W-1:0] IDX_LAST  = fmr_pkg::IDX_W'(fmr_pkg::FRAME_LEN - 1);

  state_e                        state_q, state_d;
  logic [fmr_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [fmr_pkg::BYTE_W-1:0]    header_q, trailer_q;
  logic [fmr_pkg::BYTE_W-1:0]    cap_x_q, cap_y_q, cap_r_q;
  logic                          accept;

  assign full        = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = push && !q_full_i;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    q_push_o = 1'b0;
    if (accept) begin
      if (state_q == ST_IDLE) begin
        if (rx_byte_i == header_q) begin
          state_d = ST_FRAME;
          idx_d   = IDX_FIRST;
        end
      end else if (idx_q == IDX_LAST) begin
        state_d  = ST_IDLE;
        idx_d    = '0;
        q_push_o = (rx_byte_i == trailer_q);
      end else begin
        idx_d = idx_q + fmr_pkg::IDX_W'(1);
      end
    end
  end

  assign q_data_o = '{x: cap_x_q, y: cap_y_q, r: cap_r_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      header_q  <= fmr_pkg::HEADER_RST;
      trailer_q <= fmr_pkg::TRAILER_RST;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_valid_i) begin
        case (fmr_pkg::cfg_reg_e'(cfg_index_i))
          fmr_pkg::REG_HEADER:  header_q  <= cfg_data_i;
          fmr_pkg::REG_TRAILER: trailer_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload bytes of the frame, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && state_q == ST_FRAME) begin
      case (idx_q)
        IDX_X:   cap_x_q <= rx_byte_i;
        IDX_Y:   cap_y_q <= rx_byte_i;
        IDX_R:   cap_r_q <= rx_byte_i;
        default: ;
      endcase
    end
  end

  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> idx_q == '0)
    else $error("byte index not cleared while idle");

  a_frame_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FRAME |-> (idx_q >= IDX_FIRST && idx_q <= IDX_LAST))
    else $error("byte index out of frame range");

  a_push_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |=> state_q == ST_IDLE && idx_q == '0)
    else $error("frame queued without returning to idle");

endmodule
`default_nettype wire

FILE: hdl/fmr_queue.sv
`default_nettype none
module fmr_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire fmr_pkg::frame_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  wire logic        pop_i,
  output fmr_pkg::frame_t  data_o
);

  fmr_pkg::frame_t                mem_q [fmr_pkg::QDEPTH];
  logic [fmr_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [fmr_pkg::QCNT_W-1:0]     cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == fmr_pkg::QCNT_W'(fmr_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [fmr_pkg::QPTR_W-1:0] next_ptr(logic [fmr_pkg::QPTR_W-1:0] p);
    logic [fmr_pkg::QPTR_W-1:0] n;
    if (p == fmr_pkg::QPTR_W'(fmr_pkg::QDEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + fmr_pkg::QPTR_W'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + fmr_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - fmr_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("frame pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("frame popped from an empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fmr_pkg::QCNT_W'(fmr_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

FILE: hdl/fmr_mix.sv
`default_nettype none
module fmr_mix (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              q_valid_i,
  input  wire fmr_pkg::frame_t                   q_data_i,
  output logic                                   q_pop_o,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [fmr_pkg::OUT_W-1:0]       wheel_ref_a_o,
  output logic signed [fmr_pkg::OUT_W-1:0]       wheel_ref_b_o,
  output logic signed [fmr_pkg::OUT_W-1:0]       wheel_ref_c_o,
  output logic signed [fmr_pkg::OUT_W-1:0]       wheel_ref_d_o
);

  logic                                  out_valid_q;
  logic signed [fmr_pkg::OUT_W-1:0]      ref_a_q, ref_b_q, ref_c_q, ref_d_q;
  logic signed [fmr_pkg::MIX_W-1:0]      xs, ys, rs;
  logic signed [fmr_pkg::MIX_W-1:0]      mix_a, mix_b, mix_c, mix_d;

  // output slot is free or is being drained this cycle
  assign q_pop_o = q_valid_i && (!out_valid_q || pop);
  assign empty   = !out_valid_q;

  always_comb begin
    xs    = fmr_pkg::MIX_W'(q_data_i.x) <<< fmr_pkg::SCALE_SH;
    ys    = fmr_pkg::MIX_W'(q_data_i.y) <<< fmr_pkg::SCALE_SH;
    rs    = fmr_pkg::MIX_W'(q_data_i.r) <<< fmr_pkg::SCALE_SH;
    mix_a = -(ys + xs + rs);
    mix_b = -(ys - xs + rs);
    mix_c = ys - xs - rs;
    mix_d = ys + xs - rs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ref_a_q <= fmr_pkg::to_ref(mix_a);
      ref_b_q <= fmr_pkg::to_ref(mix_b);
      ref_c_q <= fmr_pkg::to_ref(mix_c);
      ref_d_q <= fmr_pkg::to_ref(mix_d);
    end
  end

  assign wheel_ref_a_o = ref_a_q;
  assign wheel_ref_b_o = ref_b_q;
  assign wheel_ref_c_o = ref_c_q;
  assign wheel_ref_d_o = ref_d_q;

endmodule
`default_nettype wire

FILE: hdl/framed_remote_to_mecanum_refs.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+-----------------------------------------
// bytes in  | push, full                    | rx_byte_i
// results   | empty, pop                    | wheel_ref_a_o .. wheel_ref_d_o
// config    | cfg_valid_i, cfg_ready_o      | cfg_index_i, cfg_data_i
//
// one byte accepted per cycle while not full; full means the two-entry frame queue is full
// each good frame passes through the frame queue and then the result register to the ports
// the result register takes a new frame in the same cycle the old one is popped
// reset clears the parser to idle, empties the queue and restores header 0xA5, trailer 0x5A
// cfg_ready_o is always high; writes take effect on the next cycle
`default_nettype none
module framed_remote_to_mecanum_refs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [fmr_pkg::BYTE_W-1:0]          rx_byte_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic signed [fmr_pkg::OUT_W-1:0]         wheel_ref_a_o,
  output logic signed [fmr_pkg::OUT_W-1:0]         wheel_ref_b_o,
  output logic signed [fmr_pkg::OUT_W-1:0]         wheel_ref_c_o,
  output logic signed [fmr_pkg::OUT_W-1:0]         wheel_ref_d_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [fmr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [fmr_pkg::BYTE_W-1:0]          cfg_data_i
);

  logic            q_push, q_full, q_valid, q_pop;
  fmr_pkg::frame_t q_wdata, q_rdata;

  fmr_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  fmr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  fmr_mix u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .wheel_ref_a_o (wheel_ref_a_o),
    .wheel_ref_b_o (wheel_ref_b_o),
    .wheel_ref_c_o (wheel_ref_c_o),
    .wheel_ref_d_o (wheel_ref_d_o)
  );

endmodule
`default_nettype wire
